FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset
`define AAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under asynchronous active-low reset
`define AAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/aab_pkg.sv
// ----------------------------------------------------------------------------
// aab_pkg
// Widths, constants, tables and types of the ambient auto brightness block.
// ----------------------------------------------------------------------------
`default_nettype none

package aab_pkg;

	localparam int unsigned TS_W      = 32;
	localparam int unsigned LUX_W     = 24;
	localparam int unsigned LVL_W     = 10;
	localparam int unsigned PER_W     = 17;
	localparam int unsigned IVL_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 17;
	localparam int unsigned WGT_W     = 8;

	localparam int unsigned MUL_W     = 24;
	localparam int unsigned MUL_P_W   = 2 * MUL_W;
	localparam int unsigned PROD_W    = LVL_W + PER_W;

	localparam logic [LVL_W-1:0] LVL_MAX     = 10'd1000;
	localparam logic [LVL_W-1:0] LVL_RST     = 10'd1000;
	localparam logic [LVL_W-1:0] HYST        = 10'd25;
	localparam logic [LVL_W-1:0] STEP_UP     = 10'd160;
	localparam logic [LVL_W-1:0] STEP_FORCE  = 10'd1000;
	localparam logic [LVL_W-1:0] STEP_DN     = 10'd120;
	localparam logic [LVL_W-1:0] STEP_DN_DIM = 10'd70;

	localparam logic [PER_W-1:0] PERIOD_RST = 17'd1000;
	localparam logic [IVL_W-1:0] IVL_RST    = 16'd300;

	// divide by 1000 as a shift by 3, then a multiply by ceil(2^30 / 125)
	localparam int unsigned      QUO_PRE_SH = 3;
	localparam int unsigned      RECIP_SH   = 30;
	localparam logic [MUL_W-1:0] RECIP_125  = 24'd8589935;

	localparam logic [WGT_W-1:0] W_RISE     = 8'd141;
	localparam logic [WGT_W-1:0] W_FALL     = 8'd90;
	localparam logic [WGT_W-1:0] W_FALL_DIM = 8'd64;

	localparam int unsigned LUX_MAX_INT = 20000;
	localparam int unsigned LUX_DIM_INT = 30;

	localparam int unsigned N_EDGE = 8;
	localparam logic [11:0] LUX_EDGE [N_EDGE] = '{
		12'd3, 12'd10, 12'd30, 12'd80, 12'd180, 12'd400, 12'd900, 12'd2500
	};
	localparam logic [LVL_W-1:0] LUX_LEVEL [N_EDGE+1] = '{
		10'd85, 10'd135, 10'd210, 10'd320, 10'd460, 10'd620, 10'd780, 10'd900, 10'd1000
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AUTO_ENABLE     = 2'd0,
		CFG_PWM_PERIOD      = 2'd1,
		CFG_UPDATE_INTERVAL = 2'd2
	} aab_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SMUL,
		ST_SAPPLY,
		ST_TARGET,
		ST_CMUL,
		ST_QMUL,
		ST_DONE
	} aab_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/aab_tick_if.sv
// ----------------------------------------------------------------------------
// aab_tick_if
// Update tick channel: time stamp, sensor ready flag and lux sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface aab_tick_if
	import aab_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [TS_W-1:0]  now_ms;
	logic             sensor_ready;
	logic [LUX_W-1:0] lux_sample;

	modport source (output valid, output now_ms, output sensor_ready, output lux_sample,
		input ready);
	modport sink (input valid, input now_ms, input sensor_ready, input lux_sample,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/aab_result_if.sv
// ----------------------------------------------------------------------------
// aab_result_if
// Result channel: brightness level, PWM compare value and change flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface aab_result_if
	import aab_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [LVL_W-1:0] brightness_level;
	logic [PER_W-1:0] pwm_compare;
	logic             level_changed;

	modport source (output valid, output brightness_level, output pwm_compare,
		output level_changed, input ready);
	modport sink (input valid, input brightness_level, input pwm_compare,
		input level_changed, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/aab_cfg_if.sv
// ----------------------------------------------------------------------------
// aab_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface aab_cfg_if
	import aab_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ambient_auto_brightness.sv
// ----------------------------------------------------------------------------
// ambient_auto_brightness
// Ambient light driven backlight controller: smoothing, level mapping,
// rate-limited stepping and PWM compare scaling on one shared multiplier
// under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transaction per update tick (now_ms, sensor_ready, lux_sample).
//   result : exactly one transaction per tick (brightness_level, pwm_compare,
//            level_changed).
//   cfg    : register writes, index 0 auto_enable, 1 pwm_period,
//            2 update_interval_ms; always ready, write only while idle.
// Sequence: a smoothed sample runs EVAL, SMUL, SAPPLY, TARGET, CMUL, QMUL
//   and DONE; the first sample skips SMUL and SAPPLY, and a tick with no
//   sample taken goes from EVAL to CMUL; QMUL is skipped when the level is
//   at full scale. The compare divide by 1000 is a shift by 3 and a
//   multiply by the reciprocal of 125 on the shared multiplier.
// Acceptance: a new tick is taken only once the last one has left the
//   sequencer; tick.ready is high only while the sequencer is idle.
// Stall: the result sits in an output register; a new tick is accepted while
//   it waits, and the sequencer holds before writing the next result.
// Reset: registers return to auto_enable 0, pwm_period 1000,
//   update_interval_ms 300; level 1000, smoothing and timing cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ambient_auto_brightness
	import aab_pkg::*;
#(
	parameter int unsigned LUX_FRAC_BITS = 8
) (
	input  wire           clk,
	input  wire           arst_n,
	aab_tick_if.sink      tick,
	aab_result_if.source  result,
	aab_cfg_if.sink       cfg
);

	localparam int unsigned LIM_INT = LUX_MAX_INT * (2 ** LUX_FRAC_BITS);
	localparam int unsigned LIM_BITS = $clog2(LIM_INT + 1);
	localparam int unsigned SMW = (LIM_BITS < LUX_W) ? LIM_BITS : LUX_W;
	localparam logic [TS_W-1:0] LUX_LIM = TS_W'(LIM_INT);
	localparam logic [TS_W-1:0] LUX_DIM = TS_W'(LUX_DIM_INT * (2 ** LUX_FRAC_BITS));

	aab_state_t state_q, state_d;

	logic                 enable_q;
	logic                 force_q;
	logic [TS_W-1:0]      last_q;
	logic                 svalid_q;
	logic [SMW-1:0]       smooth_q;
	logic [LVL_W-1:0]     level_q;
	logic [PER_W-1:0]     period_q;
	logic [IVL_W-1:0]     ivl_q;
	logic                 out_valid_q;

	logic [TS_W-1:0]      now_q;
	logic                 rdy_q;
	logic [LUX_W-1:0]     lux_q;
	logic [LVL_W-1:0]     lvl_start_q;
	logic [SMW-1:0]       diff_q;
	logic                 rise_q;
	logic [WGT_W-1:0]     w_q;
	logic [SMW+WGT_W-1:0] prod_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [LVL_W-1:0]     out_level_q;
	logic [PER_W-1:0]     out_cmp_q;
	logic                 out_chg_q;

	logic                 tick_acc;
	logic                 cfg_acc;
	logic                 out_free;
	logic                 out_load;
	logic                 en_wr;

	logic                 elapsed;
	logic                 sample_ok;
	logic [SMW-1:0]       lux_s;
	logic                 lux_rise;
	logic [SMW-1:0]       lux_diff;
	logic [WGT_W-1:0]     lux_w;
	logic [SMW-1:0]       smooth_inc;

	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	logic [MUL_P_W-1:0]   mul_p;

	logic [LVL_W-1:0]     target;
	logic                 tgt_up;
	logic [LVL_W-1:0]     tgt_d;
	logic [LVL_W-1:0]     step_lim;
	logic [LVL_W-1:0]     step;

	assign tick_acc  = tick.valid && tick.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;
	assign en_wr     = cfg.data[0];

	assign result.valid            = out_valid_q;
	assign result.brightness_level = out_level_q;
	assign result.pwm_compare      = out_cmp_q;
	assign result.level_changed    = out_chg_q;
	assign out_free = !out_valid_q || result.ready;

	assign elapsed   = force_q || ((now_q - last_q) >= TS_W'(ivl_q));
	assign sample_ok = rdy_q && (TS_W'(lux_q) <= LUX_LIM);
	assign lux_s     = lux_q[SMW-1:0];
	assign lux_rise  = lux_s > smooth_q;
	assign lux_diff  = lux_rise ? (lux_s - smooth_q) : (smooth_q - lux_s);

	always_comb begin
		if (lux_rise) begin
			lux_w = W_RISE;
		end else if ((lux_s < smooth_q) && (TS_W'(lux_q) < LUX_DIM)) begin
			lux_w = W_FALL_DIM;
		end else begin
			lux_w = W_FALL;
		end
	end

	assign smooth_inc = prod_q[WGT_W +: SMW];

	always_comb begin
		case (state_q)
			ST_SMUL: begin
				mul_a = MUL_W'(diff_q);
				mul_b = MUL_W'(w_q);
			end
			ST_QMUL: begin
				mul_a = RECIP_125;
				mul_b = MUL_W'(dvd_q >> QUO_PRE_SH);
			end
			default: begin
				mul_a = MUL_W'(level_q);
				mul_b = MUL_W'(period_q);
			end
		endcase
	end

	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	always_comb begin
		target = LUX_LEVEL[N_EDGE];
		for (int i = int'(N_EDGE) - 1; i >= 0; i--) begin
			if (TS_W'(smooth_q) < (TS_W'(LUX_EDGE[i]) << LUX_FRAC_BITS)) begin
				target = LUX_LEVEL[i];
			end
		end
	end

	assign tgt_up = target > level_q;
	assign tgt_d  = tgt_up ? (target - level_q) : (level_q - target);

	always_comb begin
		if (tgt_up) begin
			step_lim = force_q ? STEP_FORCE : STEP_UP;
		end else begin
			step_lim = (TS_W'(smooth_q) < LUX_DIM) ? STEP_DN_DIM : STEP_DN;
		end
	end

	assign step = (tgt_d > step_lim) ? step_lim : tgt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		tick.ready = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tick.ready = 1'b1;
				if (tick.valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!enable_q || !elapsed || !sample_ok) begin
					state_d = ST_CMUL;
				end else if (!svalid_q) begin
					state_d = ST_TARGET;
				end else begin
					state_d = ST_SMUL;
				end
			end
			ST_SMUL:   state_d = ST_SAPPLY;
			ST_SAPPLY: state_d = ST_TARGET;
			ST_TARGET: state_d = ST_CMUL;
			ST_CMUL: begin
				state_d = (level_q == LVL_MAX) ? ST_DONE : ST_QMUL;
			end
			ST_QMUL:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			force_q     <= 1'b0;
			last_q      <= '0;
			svalid_q    <= 1'b0;
			smooth_q    <= '0;
			level_q     <= LVL_RST;
			period_q    <= PERIOD_RST;
			ivl_q       <= IVL_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_acc) begin
				case (aab_cfg_idx_t'(cfg.index))
					CFG_AUTO_ENABLE: begin
						if (enable_q != en_wr) begin
							force_q  <= en_wr;
							last_q   <= '0;
							svalid_q <= 1'b0;
						end else if (en_wr) begin
							force_q <= 1'b1;
						end else begin
							svalid_q <= 1'b0;
						end
						enable_q <= en_wr;
					end
					CFG_PWM_PERIOD:      period_q <= cfg.data[PER_W-1:0];
					CFG_UPDATE_INTERVAL: ivl_q <= cfg.data[IVL_W-1:0];
					default: ;
				endcase
			end else begin
				case (state_q)
					ST_EVAL: begin
						if (!enable_q) begin
							last_q   <= '0;
							svalid_q <= 1'b0;
						end else if (elapsed) begin
							last_q <= now_q;
							if (sample_ok && !svalid_q) begin
								smooth_q <= lux_s;
								svalid_q <= 1'b1;
							end
						end
					end
					ST_SAPPLY: begin
						smooth_q <= rise_q ? (smooth_q + smooth_inc) : (smooth_q - smooth_inc);
					end
					ST_TARGET: begin
						if (tgt_d >= HYST) begin
							level_q <= tgt_up ? (level_q + step) : (level_q - step);
						end
						force_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			now_q       <= tick.now_ms;
			rdy_q       <= tick.sensor_ready;
			lux_q       <= tick.lux_sample;
			lvl_start_q <= level_q;
		end
		if (state_q == ST_EVAL) begin
			diff_q <= lux_diff;
			rise_q <= lux_rise;
			w_q    <= lux_w;
		end
		if (state_q == ST_SMUL) begin
			prod_q <= mul_p[SMW+WGT_W-1:0];
		end
		if (state_q == ST_CMUL) begin
			dvd_q <= mul_p[PROD_W-1:0];
		end else if (state_q == ST_QMUL) begin
			dvd_q <= PROD_W'(mul_p[RECIP_SH +: PER_W]);
		end
		if (out_load) begin
			out_level_q <= level_q;
			out_cmp_q   <= (level_q == LVL_MAX) ? period_q : dvd_q[PER_W-1:0];
			out_chg_q   <= level_q != lvl_start_q;
		end
	end

	`AAB_ASSERT_IMP(a_level_range, clk, arst_n, 1'b1, level_q <= LVL_MAX)
	`AAB_ASSERT_NXT(a_accept_eval, clk, arst_n, tick_acc, state_q == ST_EVAL)
	`AAB_ASSERT_NXT(a_qmul_done, clk, arst_n, state_q == ST_QMUL, state_q == ST_DONE)
	`AAB_ASSERT_NXT(a_done_load, clk, arst_n, (state_q == ST_DONE) && !out_valid_q,
		out_valid_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire
